### sv/rdf_pkg.sv
// Shared types and constants for the route-request duplicate filter.
package rdf_pkg;

	// Default table depth.
	localparam int TABLE_ENTRIES_DEF = 64;

	// Result codes.
	typedef enum logic [1:0] {
		VERDICT_FORWARD = 2'd0,
		VERDICT_TTL     = 2'd1,
		VERDICT_PROB    = 2'd2,
		VERDICT_DUP     = 2'd3
	} verdict_t;

	// One stored table entry.
	typedef struct packed {
		logic [15:0] source;
		logic [15:0] destination;
		logic [7:0]  dtype;
		logic [31:0] sequence_num;
	} entry_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic     capture;
		logic     scan_clear;
		logic     scan_rd;
		logic     insert;
		logic     set_verdict;
		verdict_t verdict;
		logic     load_out;
	} rdf_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic ttl_zero;
		logic prob_drop;
		logic hit;
		logic scan_end;
		logic issued_all;
		logic out_free;
	} rdf_sts_t;

endpackage

### sv/rdf_ctrl.sv
// Sequencing state machine for the route-request duplicate filter.
module rdf_ctrl import rdf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  rdf_sts_t  sts,
	output rdf_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_INSERT,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// Input side is open only between requests
	assign in_stall = (state_q != ST_IDLE);

	// Commands and next state
	always_comb begin
		cmd       = '0;
		cmd.verdict = VERDICT_FORWARD;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_CHECK;
				end
			end
			ST_CHECK: begin
				// TTL expiry outranks the probability drop, which outranks the lookup
				if (sts.ttl_zero) begin
					cmd.set_verdict = 1'b1;
					cmd.verdict     = VERDICT_TTL;
					state_nxt       = ST_FINISH;
				end else if (sts.prob_drop) begin
					cmd.set_verdict = 1'b1;
					cmd.verdict     = VERDICT_PROB;
					state_nxt       = ST_FINISH;
				end else begin
					cmd.scan_clear = 1'b1;
					state_nxt      = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = !sts.issued_all && !sts.hit;
				if (sts.hit) begin
					cmd.set_verdict = 1'b1;
					cmd.verdict     = VERDICT_DUP;
					state_nxt       = ST_FINISH;
				end else if (sts.scan_end) begin
					state_nxt = ST_INSERT;
				end
			end
			ST_INSERT: begin
				cmd.insert      = 1'b1;
				cmd.set_verdict = 1'b1;
				cmd.verdict     = VERDICT_FORWARD;
				state_nxt       = ST_FINISH;
			end
			ST_FINISH: begin
				// Wait for the output register to free up
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

### sv/rdf_dpath.sv
// Datapath: request capture, entry table memory, scan compare and result register.
module rdf_dpath import rdf_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic [15:0] req_source,
	input  logic [15:0] req_destination,
	input  logic [7:0]  req_data_type,
	input  logic [31:0] req_sequence,
	input  logic [7:0]  request_ttl,
	input  logic [15:0] random_sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        forward,
	output logic [1:0]  verdict,
	output logic [7:0]  ttl_out,
	input  rdf_cmd_t    cmd,
	output rdf_sts_t    sts
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	// Threshold register
	logic [15:0] threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= 16'hFFFF;
		end else if (cfg_wr_en) begin
			threshold_q <= cfg_wr_data;
		end
	end

	// Captured request
	entry_t      req_q;
	logic [7:0]  ttl_dec_q;
	logic [15:0] sample_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q.source       <= req_source;
			req_q.destination  <= req_destination;
			req_q.dtype        <= req_data_type;
			req_q.sequence_num <= req_sequence;
			ttl_dec_q          <= (request_ttl == 8'd0) ? 8'd0 : request_ttl - 8'd1;
			sample_q           <= random_sample;
		end
	end

	assign sts.ttl_zero  = (ttl_dec_q == 8'd0);
	assign sts.prob_drop = (sample_q > threshold_q);

	// Insert pointer and fill count; entries below the fill count are valid
	logic [AW-1:0] ins_ptr_q;
	logic [CW-1:0] fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ins_ptr_q <= '0;
			fill_q    <= '0;
		end else if (cmd.insert) begin
			ins_ptr_q <= (ins_ptr_q == AW'(TABLE_ENTRIES - 1)) ? '0 : ins_ptr_q + 1'b1;
			if (fill_q != CW'(TABLE_ENTRIES)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Scan address counter and read-valid pipeline flag
	logic [CW-1:0] scan_idx_q;
	logic          rd_vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.scan_clear) begin
				scan_idx_q <= '0;
			end else if (cmd.scan_rd) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
		end
	end

	// Entry table: one write port, one registered read port
	entry_t mem [TABLE_ENTRIES];
	entry_t rd_s1;

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			mem[ins_ptr_q] <= req_q;
		end
		if (cmd.scan_rd) begin
			rd_s1 <= mem[scan_idx_q[AW-1:0]];
		end
	end

	// Compare the entry read last cycle
	assign sts.hit = rd_vld_s1
		&& (rd_s1.source == req_q.source)
		&& (rd_s1.destination == req_q.destination)
		&& (rd_s1.dtype == req_q.dtype)
		&& (rd_s1.sequence_num >= req_q.sequence_num);

	assign sts.issued_all = (scan_idx_q == fill_q);
	assign sts.scan_end   = sts.issued_all && !rd_vld_s1;

	// Verdict holding register
	verdict_t verdict_q;

	always_ff @(posedge clk) begin
		if (cmd.set_verdict) begin
			verdict_q <= cmd.verdict;
		end
	end

	// Output word register
	logic       out_valid_q;
	logic       forward_q;
	logic [1:0] verdict_out_q;
	logic [7:0] ttl_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			forward_q     <= (verdict_q == VERDICT_FORWARD);
			verdict_out_q <= verdict_q;
			ttl_out_q     <= (verdict_q == VERDICT_FORWARD) ? ttl_dec_q : 8'd0;
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign forward   = forward_q;
	assign verdict   = verdict_out_q;
	assign ttl_out   = ttl_out_q;

endmodule

### sv/rreq_duplicate_filter_core.sv
// Top level of the route-request duplicate filter: controller plus datapath.
//
//  Channel  Handshake             Word
//  -------  --------------------  -------------------------------------------------
//  in       in_valid / in_stall   req_source, req_destination, req_data_type,
//                                 req_sequence, request_ttl, random_sample
//  out      out_valid / out_stall forward, verdict, ttl_out
//  cfg      cfg_wr_en             cfg_wr_data (forward threshold)
//
// One request at a time. A TTL or probability drop passes from acceptance through
// the check and finish states into the output register, and the next word is taken
// once the controller is back in idle. A lookup reads the table memory one entry per
// cycle: with F valid entries the scan covers F entries (a duplicate ends it sooner)
// before the result is loaded; F is at most TABLE_ENTRIES.
// Reset clears the fill count and insert pointer; no clearing pass is needed.
// A result waiting under out_stall does not block the next input word; only a
// second finished result waits for the output register.
module rreq_duplicate_filter_core import rdf_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] req_source,
	input  logic [15:0] req_destination,
	input  logic [7:0]  req_data_type,
	input  logic [31:0] req_sequence,
	input  logic [7:0]  request_ttl,
	input  logic [15:0] random_sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        forward,
	output logic [1:0]  verdict,
	output logic [7:0]  ttl_out
);

	rdf_cmd_t cmd;
	rdf_sts_t sts;

	// Sequencer
	rdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Table and result datapath
	rdf_dpath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.req_source      (req_source),
		.req_destination (req_destination),
		.req_data_type   (req_data_type),
		.req_sequence    (req_sequence),
		.request_ttl     (request_ttl),
		.random_sample   (random_sample),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.forward         (forward),
		.verdict         (verdict),
		.ttl_out         (ttl_out),
		.cmd             (cmd),
		.sts             (sts)
	);

endmodule
